FILE: rtl/skf_pkg.sv
// shared constants and types for the scalar kalman filter core
package skf_pkg;

  localparam int DW    = 32;
  localparam int GW    = 16;
  localparam int CNT_W = $clog2(GW);
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_PROCESS_NOISE      = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_INITIAL_COVARIANCE = 2'd3;

  localparam logic [DW-1:0] RST_PROCESS_NOISE      = 32'd655;
  localparam logic [DW-1:0] RST_MEASUREMENT_NOISE  = 32'd65536;
  localparam logic [DW-1:0] RST_INITIAL_ESTIMATE   = 32'd0;
  localparam logic [DW-1:0] RST_INITIAL_COVARIANCE = 32'd65536000;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRED  = 7'b0000010,
    S_START = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MULX  = 7'b0010000,
    S_MULP  = 7'b0100000,
    S_WB    = 7'b1000000
  } skf_state_t;

endpackage

FILE: rtl/skf_div.sv
// iterative restoring divider producing a fractional gain quotient
module skf_div import skf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW:0]   divisor,
  output logic          done,
  output logic [GW-1:0] quotient
);

  logic [DW:0]    rem_r, rem_nxt;
  logic [DW:0]    den_r;
  logic [GW-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [DW+1:0]  shifted;
  logic [DW+1:0]  diff;
  logic           ge;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = ge ? diff[DW:0] : shifted[DW:0];
    quo_nxt = {quo_r[GW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished pass");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

endmodule

FILE: rtl/scalar_kalman_filter_core.sv
// scalar kalman filter core: sequencer, state, shared multiplier and output register
//
// One request is taken at a time. An update request runs from acceptance to
// the result register through a covariance prediction step, a setup step,
// the one-bit-per-cycle restoring divider that forms the gain (16 quotient
// steps and a done step), two passes through the shared 18x34 signed
// multiplier (estimate correction, then covariance scaling), a covariance
// write-back step and the hand-over into the output register. A restart
// request reloads the configured initial estimate and covariance and is
// handed to the result register with a gain of zero. A finished result waits
// in the output register until taken; the next request is accepted in the
// cycle after the sequencer has handed its result over. Configuration
// writes take effect on the next request only if made while the core is
// idle; the block itself does not enforce this.
module scalar_kalman_filter_core import skf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic signed [DW-1:0] in_measurement,
  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [DW-1:0] out_estimate,
  output logic [GW-1:0]    out_gain,
  output logic [DW-1:0]    out_covariance,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]    cfg_wdata
);

  skf_state_t state_r, state_nxt;

  logic [DW-1:0] q_r, r_r, x0_r, p0_r;
  logic [DW-1:0] est_r, est_nxt;
  logic [DW-1:0] cov_r, cov_nxt;
  logic [DW-1:0] meas_r;
  logic [DW-1:0] ppred_r;
  logic [DW:0]   innov_r;
  logic [GW-1:0] gain_r;
  logic          restart_r;
  logic          pend_r;
  logic          out_valid_r;
  logic [DW-1:0] out_est_r, out_cov_r;
  logic [GW-1:0] out_gain_r;

  logic [DW:0]   pred_sum;
  logic [DW-1:0] ppred_nxt;
  logic [DW:0]   innov_nxt;
  logic [DW-1:0] r_eff;
  logic [DW:0]   den;
  logic          div_start;
  logic          div_done;
  logic [GW-1:0] div_quo;

  logic signed [GW+1:0]    mul_a;
  logic signed [DW+1:0]    mul_b;
  logic signed [GW+DW+3:0] prod_r;
  logic [GW+1:0]           one_minus_k;
  logic signed [DW+2:0]    est_sum;
  logic [DW+2:0]           delta;

  logic in_fire;
  logic out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && !pend_r;

  // prediction and innovation
  always_comb begin
    pred_sum  = {1'b0, cov_r} + {1'b0, q_r};
    ppred_nxt = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
    innov_nxt = {meas_r[DW-1], meas_r} - {est_r[DW-1], est_r};
    r_eff     = (r_r == '0) ? DW'(1) : r_r;
    den       = {1'b0, ppred_r} + {1'b0, r_eff};
  end

  assign div_start = (state_r == S_START);

  skf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ppred_r),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // shared multiplier operands
  always_comb begin
    one_minus_k = (GW+2)'(1 << GW) - {2'b00, gain_r};
    if (state_r == S_MULP) begin
      mul_a = signed'(one_minus_k);
      mul_b = signed'({2'b00, ppred_r});
    end else begin
      mul_a = signed'({2'b00, gain_r});
      mul_b = signed'({innov_r[DW], innov_r});
    end
  end

  // estimate correction with saturation and covariance result
  always_comb begin
    delta   = prod_r[GW+DW+2:GW];
    est_sum = signed'({{3{est_r[DW-1]}}, est_r} + delta);
    if (est_sum[DW+2:DW-1] == '0 || est_sum[DW+2:DW-1] == '1) begin
      est_nxt = est_sum[DW-1:0];
    end else begin
      est_nxt = {est_sum[DW+2], {(DW-1){!est_sum[DW+2]}}};
    end
    cov_nxt = prod_r[GW+DW-1:GW];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_opcode == OP_UPDATE) begin
          state_nxt = S_PRED;
        end
      end
      S_PRED:  state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX:  state_nxt = S_MULP;
      S_MULP:  state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      restart_r   <= 1'b0;
      q_r         <= RST_PROCESS_NOISE;
      r_r         <= RST_MEASUREMENT_NOISE;
      x0_r        <= RST_INITIAL_ESTIMATE;
      p0_r        <= RST_INITIAL_COVARIANCE;
      est_r       <= RST_INITIAL_ESTIMATE;
      cov_r       <= RST_INITIAL_COVARIANCE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROCESS_NOISE:      q_r  <= cfg_wdata;
          CFG_MEASUREMENT_NOISE:  r_r  <= cfg_wdata;
          CFG_INITIAL_ESTIMATE:   x0_r <= cfg_wdata;
          CFG_INITIAL_COVARIANCE: p0_r <= cfg_wdata;
          default: ;
        endcase
      end
      // restart
      if (in_fire && in_opcode == OP_RESTART) begin
        est_r     <= x0_r;
        cov_r     <= p0_r;
        restart_r <= 1'b1;
        pend_r    <= 1'b1;
      end
      if (state_r == S_MULP) begin
        est_r <= est_nxt;
      end
      if (state_r == S_WB) begin
        cov_r     <= cov_nxt;
        restart_r <= 1'b0;
        pend_r    <= 1'b1;
      end
      // hand result to output register
      if (pend_r && out_free) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      meas_r <= in_measurement;
    end
    if (state_r == S_PRED) begin
      ppred_r <= ppred_nxt;
      innov_r <= innov_nxt;
    end
    if (div_done) begin
      gain_r <= div_quo;
    end
    if (state_r == S_MULX || state_r == S_MULP) begin
      prod_r <= mul_a * mul_b;
    end
    if (pend_r && out_free) begin
      out_est_r  <= est_r;
      out_cov_r  <= cov_r;
      out_gain_r <= restart_r ? '0 : gain_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_estimate   = signed'(out_est_r);
  assign out_gain       = out_gain_r;
  assign out_covariance = out_cov_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE && !pend_r)
    else $error("request accepted while busy");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide phase");

  a_pred_not_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_START |-> ppred_r >= cov_r)
    else $error("predicted covariance below prior covariance");

  a_restart_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_free && restart_r |=> out_gain == '0)
    else $error("restart result carries nonzero gain");

endmodule

FILE: tb/tb_scalar_kalman_filter_core.sv
// self-checking testbench for the scalar kalman filter core: directed table, random phases
module tb_scalar_kalman_filter_core;
  import skf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 30;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 7;
  localparam int PER_PHASE   = 86;

  localparam longint EST_MAX = (longint'(1) <<< (DW-1)) - 1;
  localparam longint EST_MIN = -(longint'(1) <<< (DW-1));

  typedef struct packed {
    logic signed [DW-1:0] est;
    logic [GW-1:0]        gain;
    logic [DW-1:0]        cov;
  } kf_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    data;
    bit               typed;
    kf_result_t       want;
  } plan_row_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 in_opcode      = OP_UPDATE;
  logic signed [DW-1:0] in_measurement = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic signed [DW-1:0] out_estimate;
  logic [GW-1:0]        out_gain;
  logic [DW-1:0]        out_covariance;
  logic                 cfg_we         = 1'b0;
  logic [IDX_W-1:0]     cfg_index      = CFG_PROCESS_NOISE;
  logic [DW-1:0]        cfg_wdata      = '0;

  kf_result_t pending_results[$];
  plan_row_t  plan[$];

  // filter state and register copies
  logic [DW-1:0]        q_reg  = RST_PROCESS_NOISE;
  logic [DW-1:0]        r_reg  = RST_MEASUREMENT_NOISE;
  logic [DW-1:0]        x0_reg = RST_INITIAL_ESTIMATE;
  logic [DW-1:0]        p0_reg = RST_INITIAL_COVARIANCE;
  logic signed [DW-1:0] est_st = RST_INITIAL_ESTIMATE;
  logic [DW-1:0]        cov_st = RST_INITIAL_COVARIANCE;

  int n_fail       = 0;
  int n_checked    = 0;
  int n_requests   = 0;
  int n_restarts   = 0;
  int n_cfg_writes = 0;
  bit idle_on        = 1'b1;
  bit long_hold_done = 1'b0;

  scalar_kalman_filter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain),
    .out_covariance (out_covariance),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic filter_step(input logic op, input logic signed [DW-1:0] meas,
                             output kf_result_t res);
    logic [DW:0]   p_sum;
    logic [DW-1:0] p_pred;
    logic [63:0]   den;
    logic [63:0]   k_full;
    logic [63:0]   cov_full;
    logic [GW-1:0] k;
    longint        innov;
    longint        x_new;
    k = '0;
    if (op == OP_RESTART) begin
      est_st = x0_reg;
      cov_st = p0_reg;
    end else begin
      p_sum  = {1'b0, cov_st} + {1'b0, q_reg};
      p_pred = p_sum[DW] ? '1 : p_sum[DW-1:0];
      // zero measurement noise behaves as the smallest legal value
      den    = 64'(p_pred) + ((r_reg == '0) ? 64'd1 : 64'(r_reg));
      k_full = (64'(p_pred) << GW) / den;
      k      = k_full[GW-1:0];
      innov  = longint'(meas) - longint'(est_st);
      x_new  = longint'(est_st) + ((longint'(k) * innov) >>> GW);
      if (x_new > EST_MAX) x_new = EST_MAX;
      if (x_new < EST_MIN) x_new = EST_MIN;
      est_st   = x_new[DW-1:0];
      cov_full = ((64'd1 << GW) - 64'(k)) * 64'(p_pred);
      cov_st   = cov_full[GW +: DW];
    end
    res.est  = est_st;
    res.gain = k;
    res.cov  = cov_st;
  endtask

  function automatic plan_row_t req(logic op, logic [DW-1:0] meas);
    plan_row_t row;
    row.kind  = ROW_REQ;
    row.op    = op;
    row.idx   = CFG_PROCESS_NOISE;
    row.data  = meas;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t req_typed(logic op, logic [DW-1:0] meas, logic [DW-1:0] est,
                                          logic [GW-1:0] gain, logic [DW-1:0] cov);
    plan_row_t row;
    row       = req(op, meas);
    row.typed = 1'b1;
    row.want  = {est, gain, cov};
    return row;
  endfunction

  function automatic plan_row_t reg_wr(logic [IDX_W-1:0] idx, logic [DW-1:0] val);
    plan_row_t row;
    row      = req(OP_UPDATE, val);
    row.kind = ROW_CFG;
    row.idx  = idx;
    return row;
  endfunction

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7fffffff;
      3:       return 32'h80000000;
      4:       return $urandom_range(1, 1 << 18);
      5:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_measurement();
    case ($urandom_range(0, 5))
      0:       return pick_word();
      1:       return est_st + $urandom_range(0, 1 << 17) - (1 << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PROCESS_NOISE:      q_reg  = val;
      CFG_MEASUREMENT_NOISE:  r_reg  = val;
      CFG_INITIAL_ESTIMATE:   x0_reg = val;
      CFG_INITIAL_COVARIANCE: p0_reg = val;
    endcase
    n_cfg_writes++;
  endtask

  task automatic offer_request(input logic op, input logic [DW-1:0] meas, input bit typed,
                               input kf_result_t want);
    kf_result_t predicted;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_measurement <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_step(op, meas, predicted);
    pending_results.push_back(typed ? want : predicted);
    n_requests++;
    if (op == OP_RESTART) n_restarts++;
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : result_sink
    int         hold_left;
    kf_result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: estimate %h gain %h covariance %h",
                 out_estimate, out_gain, out_covariance);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          if (out_estimate !== want.est) begin
            $error("estimate: expected %h, got %h", want.est, out_estimate);
            n_fail++;
          end
          if (out_gain !== want.gain) begin
            $error("gain: expected %h, got %h", want.gain, out_gain);
            n_fail++;
          end
          if (out_covariance !== want.cov) begin
            $error("covariance: expected %h, got %h", want.cov, out_covariance);
            n_fail++;
          end
          n_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && n_checked >= 60) begin
        // long back-pressure so the core fills up and stalls its input
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_ready     <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left  = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no completion after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    plan_row_t row;
    logic      op;
    bit        drained;
    // after reset the core holds the register reset values
    plan.push_back(req_typed(OP_RESTART, 32'h5a5a5a5a, RST_INITIAL_ESTIMATE, 16'd0,
                             RST_INITIAL_COVARIANCE));
    plan.push_back(req(OP_UPDATE, 32'h7fffffff));
    plan.push_back(req(OP_UPDATE, 32'h80000000));
    plan.push_back(req(OP_UPDATE, 32'h00000000));
    plan.push_back(req(OP_UPDATE, 32'h00000001));
    plan.push_back(req(OP_UPDATE, 32'hffffffff));
    // zero noise and zero covariance: gain stays zero, state frozen
    plan.push_back(reg_wr(CFG_PROCESS_NOISE, 32'd0));
    plan.push_back(reg_wr(CFG_MEASUREMENT_NOISE, 32'd0));
    plan.push_back(reg_wr(CFG_INITIAL_ESTIMATE, 32'h7fffffff));
    plan.push_back(reg_wr(CFG_INITIAL_COVARIANCE, 32'd0));
    plan.push_back(req_typed(OP_RESTART, 32'ha5a5a5a5, 32'h7fffffff, 16'd0, 32'd0));
    plan.push_back(req_typed(OP_UPDATE, 32'h80000000, 32'h7fffffff, 16'd0, 32'd0));
    plan.push_back(req_typed(OP_UPDATE, 32'h00010000, 32'h7fffffff, 16'd0, 32'd0));
    // covariance sum saturates at all ones
    plan.push_back(reg_wr(CFG_PROCESS_NOISE, 32'hffffffff));
    plan.push_back(reg_wr(CFG_INITIAL_COVARIANCE, 32'hffffffff));
    plan.push_back(req_typed(OP_RESTART, 32'h00000000, 32'h7fffffff, 16'd0, 32'hffffffff));
    plan.push_back(req(OP_UPDATE, 32'h80000000));
    plan.push_back(req(OP_UPDATE, 32'h7fffffff));
    plan.push_back(req(OP_UPDATE, 32'h55555555));
    // largest noise against a tiny covariance, estimate at the negative extreme
    plan.push_back(reg_wr(CFG_MEASUREMENT_NOISE, 32'hffffffff));
    plan.push_back(reg_wr(CFG_PROCESS_NOISE, 32'd1));
    plan.push_back(reg_wr(CFG_INITIAL_ESTIMATE, 32'h80000000));
    plan.push_back(reg_wr(CFG_INITIAL_COVARIANCE, 32'd1));
    plan.push_back(req_typed(OP_RESTART, 32'hffffffff, 32'h80000000, 16'd0, 32'd1));
    plan.push_back(req(OP_UPDATE, 32'h7fffffff));
    plan.push_back(req(OP_UPDATE, 32'h80000000));
    plan.push_back(req(OP_UPDATE, 32'haaaaaaaa));
    plan.push_back(reg_wr(CFG_MEASUREMENT_NOISE, 32'd1));
    plan.push_back(reg_wr(CFG_PROCESS_NOISE, RST_PROCESS_NOISE));
    plan.push_back(reg_wr(CFG_INITIAL_COVARIANCE, 32'd65536));
    plan.push_back(reg_wr(CFG_INITIAL_ESTIMATE, 32'h00010000));
    plan.push_back(req_typed(OP_RESTART, 32'h12345678, 32'h00010000, 16'd0, 32'd65536));
    plan.push_back(req(OP_UPDATE, 32'h7fffffff));
    plan.push_back(req(OP_UPDATE, 32'h80000000));
    plan.push_back(req_typed(OP_RESTART, 32'h00000000, 32'h00010000, 16'd0, 32'd65536));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drained = 1'b1;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        if (!drained) drain_results();
        drained = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        sender_gap();
        offer_request(row.op, row.data, row.typed, row.want);
        drained = 1'b0;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      idle_on = (p != 2) && (p != PHASES - 1);
      write_reg(CFG_PROCESS_NOISE, (p == 0) ? RST_PROCESS_NOISE : pick_word());
      write_reg(CFG_MEASUREMENT_NOISE, (p == 0) ? RST_MEASUREMENT_NOISE : pick_word());
      write_reg(CFG_INITIAL_ESTIMATE, pick_word());
      write_reg(CFG_INITIAL_COVARIANCE, pick_word());
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        else sender_gap();
        op = ($urandom_range(0, 11) == 0) ? OP_RESTART : OP_UPDATE;
        offer_request(op, pick_measurement(), 1'b0, '0);
      end
    end

    drain_results();
    $display("covered %0d requests including %0d restarts over %0d register writes",
             n_requests, n_restarts, n_cfg_writes);
    $display("%0d results compared, %0d field mismatches", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
